>>> design/keyword_substitution_cipher_defines.svh
// assertion macros shared by the cipher rtl
// depends on: clk and rst_n in the scope of each use
`ifndef KEYWORD_SUBSTITUTION_CIPHER_DEFINES_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_DEFINES_SVH

// plain invariant, checked every cycle out of reset
`define KSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define KSC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ksc_pkg.sv
// constants, command codes and letter helpers for the keyword cipher
// no dependencies
package ksc_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int POS_W         = $clog2(ALPHABET_SIZE);
  localparam int CNT_W         = $clog2(ALPHABET_SIZE + 1);
  localparam int CMD_W         = 2;
  localparam int LETTER_W      = 8;
  localparam int CIPHER_W      = 7;

  localparam logic [LETTER_W-1:0] LETTER_BASE = 8'd97;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_ENCRYPT = 2'd2
  } cmd_t;

  function automatic logic letter_valid(input logic [LETTER_W-1:0] letter);
    logic [LETTER_W-1:0] diff;
    diff = letter - LETTER_BASE;
    return (letter >= LETTER_BASE) && (diff < LETTER_W'(ALPHABET_SIZE));
  endfunction

  // position inside the alphabet, zero for anything outside it
  function automatic logic [POS_W-1:0] letter_pos(input logic [LETTER_W-1:0] letter);
    logic [LETTER_W-1:0] diff;
    diff = letter - LETTER_BASE;
    if (letter_valid(letter)) begin
      return diff[POS_W-1:0];
    end
    return '0;
  endfunction

endpackage

>>> design/keyword_substitution_cipher.sv
// keyword substitution cipher, top level with the cipher table memory
// depends on: ksc_pkg, keyword_substitution_cipher_defines.svh
`include "keyword_substitution_cipher_defines.svh"

// Keyword substitution cipher over the lower-case letters a..z. Each input
// item carries a command in in_tuser (clear key, append key letter, encrypt
// letter) and an ASCII byte in in_tdata. Appended key letters fill the cipher
// alphabet in order; a letter outside a..z, a repeated letter, or one that
// arrives once the alphabet is full or already completed is dropped and its
// result item carries key_error. The first encrypt after key loading fills
// the rest of the alphabet with the unused letters in alphabetical order;
// every encrypt then returns the cipher letter at the plaintext letter's
// position (a byte outside a..z counts as 'a'). Clear and the unused command
// code give no result item. A clear finishes in S_IDLE; an append writes the
// table there and sends its result from S_SEND; an encrypt reads the table,
// then passes S_READ and S_SEND. The first encrypt after key loading runs
// S_FILL, one letter per cycle through the table's single write port, then
// S_ISSUE. The table needs no clearing after reset: entries are read only
// after the fill has written all of them. One item is in work at a time, but
// a new item is taken while a finished result waits in the output register.
module keyword_substitution_cipher (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ksc_pkg::LETTER_W-1:0] in_tdata,   // [7:0] letter
  input  logic [ksc_pkg::CMD_W-1:0]    in_tuser,   // [1:0] command
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [7:0]                   out_tdata   // [6:0] cipher_letter, [7] key_error
);
  import ksc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_ISSUE,
    S_READ,
    S_SEND
  } state_t;

  // cipher table: one write port, one registered read port
  logic [POS_W-1:0] table_mem [ALPHABET_SIZE];
  logic [POS_W-1:0] rd_data_r;
  logic [POS_W-1:0] rd_addr;
  logic [POS_W-1:0] wr_addr;
  logic [POS_W-1:0] wr_data;
  logic             mem_we;

  state_t                 state_r, state_nxt;
  logic [ALPHABET_SIZE-1:0] used_r, used_nxt;
  logic [CNT_W-1:0]       key_count_r, key_count_nxt;
  logic                   complete_r, complete_nxt;
  logic [POS_W-1:0]       fill_idx_r, fill_idx_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [CIPHER_W-1:0]    res_letter_r, res_letter_nxt;
  logic                   res_err_r, res_err_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CIPHER_W-1:0]    out_letter_r, out_letter_nxt;
  logic                   out_err_r, out_err_nxt;

  logic             in_fire;
  cmd_t             in_cmd;
  logic [POS_W-1:0] in_pos;
  logic             in_ok;
  logic             room;
  logic             fill_last;
  logic             append_ok;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_cmd    = cmd_t'(in_tuser);
  assign in_pos    = letter_pos(in_tdata);
  assign in_ok     = letter_valid(in_tdata);
  assign room      = key_count_r < CNT_W'(ALPHABET_SIZE);
  assign fill_last = fill_idx_r == POS_W'(ALPHABET_SIZE - 1);
  assign append_ok = in_ok && !complete_r && room && !used_r[in_pos];

  // during idle the read is issued straight from the incoming letter
  assign rd_addr = (state_r == S_IDLE) ? in_pos : pos_r;
  assign wr_addr = key_count_r[POS_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    key_count_nxt  = key_count_r;
    complete_nxt   = complete_r;
    fill_idx_nxt   = fill_idx_r;
    pos_nxt        = pos_r;
    res_letter_nxt = res_letter_r;
    res_err_nxt    = res_err_r;
    out_letter_nxt = out_letter_r;
    out_err_nxt    = out_err_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    mem_we         = 1'b0;
    wr_data        = in_pos;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_CLEAR: begin
              used_nxt      = '0;
              key_count_nxt = '0;
              complete_nxt  = 1'b0;
            end
            CMD_APPEND: begin
              if (append_ok) begin
                mem_we                = 1'b1;
                key_count_nxt         = key_count_r + CNT_W'(1);
                used_nxt[in_pos]      = 1'b1;
              end
              res_letter_nxt = '0;
              res_err_nxt    = !append_ok;
              state_nxt      = S_SEND;
            end
            CMD_ENCRYPT: begin
              pos_nxt = in_pos;
              if (complete_r) begin
                state_nxt = S_READ;
              end else begin
                fill_idx_nxt = '0;
                state_nxt    = S_FILL;
              end
            end
            default: begin
              // unused code: dropped without a result
            end
          endcase
        end
      end
      S_FILL: begin
        // one letter per cycle, unused ones go to the next free entry
        wr_data = fill_idx_r;
        if (!used_r[fill_idx_r] && room) begin
          mem_we               = 1'b1;
          key_count_nxt        = key_count_r + CNT_W'(1);
          used_nxt[fill_idx_r] = 1'b1;
        end
        if (fill_last) begin
          complete_nxt = 1'b1;
          state_nxt    = S_ISSUE;
        end else begin
          fill_idx_nxt = fill_idx_r + POS_W'(1);
        end
      end
      S_ISSUE: begin
        // last fill write has landed, read now sees it
        state_nxt = S_READ;
      end
      S_READ: begin
        res_letter_nxt = LETTER_BASE[CIPHER_W-1:0] + CIPHER_W'(rd_data_r);
        res_err_nxt    = 1'b0;
        state_nxt      = S_SEND;
      end
      S_SEND: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_letter_nxt = res_letter_r;
          out_err_nxt    = res_err_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      key_count_r <= '0;
      complete_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      key_count_r <= key_count_nxt;
      complete_r  <= complete_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fill_idx_r   <= fill_idx_nxt;
    pos_r        <= pos_nxt;
    res_letter_r <= res_letter_nxt;
    res_err_r    <= res_err_nxt;
    out_letter_r <= out_letter_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_err_r, out_letter_r};

  // every table entry written matches exactly one used letter
  `KSC_ASSERT(a_count_matches_used, $countones(used_r) == int'(key_count_r),
    "key count and used letters disagree")
  `KSC_ASSERT(a_count_bound, key_count_r <= CNT_W'(ALPHABET_SIZE),
    "key count beyond alphabet")
  `KSC_ASSERT_IMPL(a_complete_full, complete_r, key_count_r == CNT_W'(ALPHABET_SIZE),
    "completed table not full")
  `KSC_ASSERT_NEXT(a_fill_ends, state_r == S_FILL && fill_last,
    complete_r && state_r == S_ISSUE, "fill did not finish")

endmodule

>>> test/tb_top.sv
// self-checking testbench for keyword_substitution_cipher: directed key and encrypt
// items, then random key sequences under random stalls on both stream sides
// depends on: ksc_pkg and the keyword_substitution_cipher rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ksc_pkg::*;

  // command code the block ignores: no result item, no state change
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 567;
  // cycles with no handshake on either side before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // worst case of one encrypt with the alphabet fill in front of it, with margin
  localparam int DRAIN_CYCLES = 3 * (ALPHABET_SIZE + 4);

  typedef struct packed {
    logic [CIPHER_W-1:0] cipher_letter;
    logic                key_error;
  } cipher_result_t;

  // keeps its own copy of the cipher alphabet and predicts one result per
  // append or encrypt item
  class keyword_cipher_scoreboard;
    logic [POS_W-1:0]         alphabet [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] used_mask = '0;
    int                       entries = 0;
    bit                       alphabet_done = 1'b0;
    cipher_result_t           pending_results [$];
    int                       mismatch_count = 0;

    // position of a letter inside the alphabet, -1 when outside it
    function int position_of(logic [LETTER_W-1:0] letter);
      int v;
      v = letter;
      if (v >= LETTER_BASE && v - LETTER_BASE < ALPHABET_SIZE) begin
        return v - LETTER_BASE;
      end
      return -1;
    endfunction

    function void note_item(logic [CMD_W-1:0] cmd, logic [LETTER_W-1:0] letter);
      cipher_result_t exp;
      int pos;
      pos = position_of(letter);
      exp = '0;
      case (cmd)
        CMD_CLEAR: begin
          used_mask     = '0;
          entries       = 0;
          alphabet_done = 1'b0;
        end
        CMD_APPEND: begin
          exp.key_error = 1'b1;
          if (pos >= 0 && !alphabet_done && entries < ALPHABET_SIZE && !used_mask[pos]) begin
            alphabet[entries] = POS_W'(pos);
            entries++;
            used_mask[pos] = 1'b1;
            exp.key_error  = 1'b0;
          end
          pending_results.push_back(exp);
        end
        CMD_ENCRYPT: begin
          // first encrypt after key loading: unused letters in alphabetical order
          if (!alphabet_done) begin
            for (int l = 0; l < ALPHABET_SIZE; l++) begin
              if (!used_mask[l] && entries < ALPHABET_SIZE) begin
                alphabet[entries] = POS_W'(l);
                entries++;
                used_mask[l] = 1'b1;
              end
            end
            alphabet_done = 1'b1;
          end
          if (pos < 0) begin
            pos = 0;
          end
          exp.cipher_letter = CIPHER_W'(LETTER_BASE + alphabet[pos]);
          pending_results.push_back(exp);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [7:0] data);
      cipher_result_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, data);
        mismatch_count++;
        return;
      end
      exp = pending_results.pop_front();
      if (data[CIPHER_W-1:0] !== exp.cipher_letter) begin
        $display("%0t: cipher_letter mismatch, expected %0d, actual %0d",
                 $time, exp.cipher_letter, data[CIPHER_W-1:0]);
        mismatch_count++;
      end
      if (data[7] !== exp.key_error) begin
        $display("%0t: key_error mismatch, expected %0b, actual %0b",
                 $time, exp.key_error, data[7]);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [LETTER_W-1:0] in_tdata = '0;    // [7:0] letter
  logic [CMD_W-1:0]    in_tuser = '0;    // [1:0] command
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;        // [6:0] cipher_letter, [7] key_error

  keyword_cipher_scoreboard sb = new();

  // idle percentages of the two stream sides, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  keyword_substitution_cipher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // receiver side: random back-pressure at the current idle rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // both handshakes are seen here with the values from before the edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_item(in_tuser, in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata);
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL keyword_substitution_cipher");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one item on the input side, with random gaps in front of it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [LETTER_W-1:0] letter);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= letter;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    if (cmd != CMD_UNUSED) begin
      items_sent++;
    end
  endtask

  // a letter inside a..z with a chance of valid_pct percent, otherwise any byte
  function automatic logic [LETTER_W-1:0] pick_letter(input int valid_pct);
    if ($urandom_range(99) < valid_pct) begin
      return LETTER_W'(LETTER_BASE + $urandom_range(ALPHABET_SIZE - 1));
    end
    return LETTER_W'($urandom_range(255));
  endfunction

  // key run: clear most of the time, key letters, then plaintext, sometimes one more append
  task automatic send_key_sequence();
    int order [ALPHABET_SIZE];
    int j;
    int swap;
    // sometimes keep the old key, so appends hit a completed alphabet
    if ($urandom_range(99) < 80) begin
      send_item(CMD_CLEAR, pick_letter(50));
    end
    if ($urandom_range(99) < 25) begin
      // full shuffled key, then up to three letters past the end of the alphabet
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        order[i] = i;
      end
      for (int i = ALPHABET_SIZE - 1; i > 0; i--) begin
        j = $urandom_range(i);
        swap = order[i];
        order[i] = order[j];
        order[j] = swap;
      end
      for (int i = 0; i < ALPHABET_SIZE; i++) begin
        send_item(CMD_APPEND, LETTER_W'(LETTER_BASE + order[i]));
      end
      repeat ($urandom_range(3)) send_item(CMD_APPEND, pick_letter(80));
    end else begin
      repeat ($urandom_range(12)) send_item(CMD_APPEND, pick_letter(90));
    end
    repeat ($urandom_range(1, 10)) send_item(CMD_ENCRYPT, pick_letter(90));
    if ($urandom_range(99) < 15) begin
      send_item(CMD_APPEND, pick_letter(90));
    end
  endtask

  initial begin
    int phase_goal;
    send_idle_pct = 37;
    recv_idle_pct = 64;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty key after reset: the fill gives the identity alphabet
    send_item(CMD_ENCRYPT, LETTER_BASE);
    send_item(CMD_ENCRYPT, 8'hff);                       // plaintext outside -> 'a'
    send_item(CMD_ENCRYPT, 8'h00);
    send_item(CMD_ENCRYPT, LETTER_W'(LETTER_BASE + 25));
    send_item(CMD_APPEND, LETTER_W'(LETTER_BASE + 10));  // alphabet already complete
    send_item(CMD_CLEAR, 8'h00);
    send_item(CMD_APPEND, LETTER_W'(LETTER_BASE + 25));
    send_item(CMD_APPEND, LETTER_BASE);
    send_item(CMD_APPEND, LETTER_W'(LETTER_BASE + 25)); // repeated key letter
    send_item(CMD_APPEND, LETTER_W'(LETTER_BASE - 1));  // just below a
    send_item(CMD_APPEND, LETTER_W'(LETTER_BASE + 26)); // just above z
    send_item(CMD_APPEND, 8'h00);
    send_item(CMD_APPEND, 8'hff);
    send_item(CMD_UNUSED, 8'h55);                        // ignored command code
    send_item(CMD_APPEND, LETTER_W'(LETTER_BASE + 4));
    send_item(CMD_ENCRYPT, LETTER_BASE);
    send_item(CMD_ENCRYPT, LETTER_W'(LETTER_BASE + 1));
    send_item(CMD_ENCRYPT, LETTER_W'(LETTER_BASE + 2));
    send_item(CMD_ENCRYPT, LETTER_W'(LETTER_BASE + 25));
    send_item(CMD_ENCRYPT, LETTER_W'(LETTER_BASE - 1));
    send_item(CMD_UNUSED, 8'haa);
    send_item(CMD_CLEAR, 8'hff);

    // random part in three idle phases
    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 64;
        end
        1: begin
          send_idle_pct = 64;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_goal = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_goal) begin
        if ($urandom_range(99) < 85) begin
          send_key_sequence();
        end else begin
          // noise: any command code, any byte
          send_item(CMD_W'($urandom_range(3)), LETTER_W'($urandom_range(255)));
        end
      end
    end
    in_tvalid <= 1'b0;

    // wait out the expected results, then look for stray ones
    while (sb.pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("PASS keyword_substitution_cipher");
    end else begin
      $display("FAIL keyword_substitution_cipher");
    end
    $finish;
  end

endmodule
